// File: sv/mspb_pkg.sv
// shared types and constants for the one-bit sprite blitter
`default_nettype none
package mspb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 120;
  localparam int unsigned SCREEN_HEIGHT = 60;

  localparam int unsigned NUM_LANES  = 8;
  localparam int unsigned LANE_IDX_W = $clog2(NUM_LANES);
  localparam int unsigned COUNT_W    = $clog2(NUM_LANES + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH  = 3'd0,
    CFG_SPRITE_HEIGHT = 3'd1,
    CFG_DEST_X        = 3'd2,
    CFG_DEST_Y        = 3'd3,
    CFG_USE_MASK      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] sprite_byte;
    logic [7:0] mask_byte;
  } in_item_t;

  typedef struct packed {
    logic       write_pixel;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_value;
    logic       last_of_byte;
    logic       sprite_done;
  } out_item_t;

  // per-byte values shared by all lanes
  typedef struct packed {
    logic [17:0]        base_x;
    logic [7:0]         pixel_y;
    logic               row_on;
    logic               use_mask;
    logic [COUNT_W-1:0] count;
    logic               end_sprite;
  } lane_ctl_t;

endpackage : mspb_pkg
`default_nettype wire

// File: sv/mspb_lane.sv
// one pixel lane: screen clip, mask test and result fields for one bit of the byte
`default_nettype none
module mspb_lane (
  input  mspb_pkg::lane_ctl_t                     ctl_i,
  input  logic [mspb_pkg::LANE_IDX_W-1:0]         lane_idx_i,
  input  logic                                    sprite_bit_i,
  input  logic                                    mask_bit_i,
  output mspb_pkg::out_item_t                     item_o
);
  import mspb_pkg::*;

  logic [17:0] x;
  logic        x_on;
  logic        wr;
  logic        last;

  // x is two's complement; the sign bit rules out the left side
  assign x    = ctl_i.base_x + {{(18-LANE_IDX_W){1'b0}}, lane_idx_i};
  assign x_on = !x[17] && (x < 18'(SCREEN_WIDTH));
  assign wr   = ctl_i.row_on && x_on && (!ctl_i.use_mask || mask_bit_i);
  assign last = ({1'b0, lane_idx_i} + COUNT_W'(1)) == ctl_i.count;

  always_comb begin
    item_o.write_pixel  = wr;
    item_o.pixel_x      = wr ? x[7:0] : 8'd0;
    item_o.pixel_y      = wr ? ctl_i.pixel_y : 8'd0;
    item_o.pixel_value  = wr & sprite_bit_i;
    item_o.last_of_byte = last;
    item_o.sprite_done  = last & ctl_i.end_sprite;
  end

endmodule : mspb_lane
`default_nettype wire

// File: sv/mspb_ser.sv
// result buffer that holds the lane results of one byte and hands them out one a cycle while out_stall_i is low
`default_nettype none
module mspb_ser (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  mspb_pkg::out_item_t [mspb_pkg::NUM_LANES-1:0] lanes_i,
  output logic                                       free_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output mspb_pkg::out_item_t                        out_item_o
);
  import mspb_pkg::*;

  out_item_t [NUM_LANES-1:0] items_q;
  logic [LANE_IDX_W-1:0]     idx_q, idx_d;
  logic                      busy_q, busy_d;
  logic                      out_acc;
  logic                      done;

  assign out_item_o  = items_q[idx_q];
  assign out_valid_o = busy_q;
  assign out_acc     = busy_q && !out_stall_i;
  // taking the last result of a byte frees the buffer in the same cycle
  assign done        = out_acc && out_item_o.last_of_byte;
  assign free_o      = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (out_acc) begin
      idx_d = idx_q + LANE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      items_q <= lanes_i;
    end
  end

endmodule : mspb_ser
`default_nettype wire

// File: sv/mono_sprite_blit_clip_mask.sv
// top level: configuration registers, sprite position tracking, eight pixel lanes
// the first result of a byte is offered in the cycle after the byte is accepted
// throughput: one result per cycle while out_stall is low; a byte gives one result per pixel (1 to 8),
//   all through the single result channel; the next byte is taken as the last result leaves
// a byte of an empty sprite is accepted and gives no result
// reset: position goes to column 0, row 0 and registers to their defaults at once
`default_nettype none
module mono_sprite_blit_clip_mask (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mspb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mspb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mspb_pkg::in_item_t                 in_item_i,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mspb_pkg::out_item_t                out_item_o
);
  import mspb_pkg::*;

  logic [7:0]  width_q, height_q;
  logic [15:0] dest_x_q, dest_y_q;
  logic        use_mask_q;
  logic [7:0]  col_q, col_d, row_q, row_d;

  logic        cfg_acc, cfg_hit;
  logic        in_acc, empty, stale, load, free;
  logic [7:0]  col_eff, row_eff;
  logic [8:0]  rem;
  logic [COUNT_W-1:0] count;
  logic        last_in_row, last_row;
  logic [16:0] y;
  lane_ctl_t   ctl;
  out_item_t [NUM_LANES-1:0] lane_items;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = !free;
  assign in_acc    = in_valid && !in_stall;

  assign empty   = (width_q == 8'd0) || (height_q == 8'd0);
  assign stale   = (col_q >= width_q) || (row_q >= height_q);
  assign col_eff = stale ? 8'd0 : col_q;
  assign row_eff = stale ? 8'd0 : row_q;
  assign load    = in_acc && !empty;

  assign rem         = {1'b0, width_q} - {1'b0, col_eff};
  assign count       = (rem > 9'(NUM_LANES)) ? COUNT_W'(NUM_LANES) : rem[COUNT_W-1:0];
  assign last_in_row = ({1'b0, col_eff} + {{(9-COUNT_W){1'b0}}, count}) >= {1'b0, width_q};
  assign last_row    = ({1'b0, row_eff} + 9'd1) >= {1'b0, height_q};
  assign y           = {dest_y_q[15], dest_y_q} + {9'd0, row_eff};

  always_comb begin
    ctl.base_x     = {{2{dest_x_q[15]}}, dest_x_q} + {10'd0, col_eff};
    ctl.pixel_y    = y[7:0];
    ctl.row_on     = !y[16] && (y < 17'(SCREEN_HEIGHT));
    ctl.use_mask   = use_mask_q;
    ctl.count      = count;
    ctl.end_sprite = last_in_row && last_row;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mspb_lane u_lane (
      .ctl_i        (ctl),
      .lane_idx_i   (LANE_IDX_W'(i)),
      .sprite_bit_i (in_item_i.sprite_byte[i]),
      .mask_bit_i   (in_item_i.mask_byte[i]),
      .item_o       (lane_items[i])
    );
  end

  mspb_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .lanes_i     (lane_items),
    .free_o      (free),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_reg_e'(cfg_index_i))
      CFG_SPRITE_WIDTH, CFG_SPRITE_HEIGHT, CFG_DEST_X, CFG_DEST_Y, CFG_USE_MASK: begin
        cfg_hit = 1'b1;
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_acc && cfg_hit) begin
      col_d = 8'd0;
      row_d = 8'd0;
    end else if (load) begin
      if (last_in_row) begin
        col_d = 8'd0;
        row_d = last_row ? 8'd0 : row_eff + 8'd1;
      end else begin
        col_d = col_eff + 8'(NUM_LANES);
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 8'd8;
      height_q   <= 8'd8;
      dest_x_q   <= 16'd0;
      dest_y_q   <= 16'd0;
      use_mask_q <= 1'b0;
      col_q      <= 8'd0;
      row_q      <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_acc) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SPRITE_WIDTH:  width_q    <= cfg_data_i[7:0];
          CFG_SPRITE_HEIGHT: height_q   <= cfg_data_i[7:0];
          CFG_DEST_X:        dest_x_q   <= cfg_data_i;
          CFG_DEST_Y:        dest_y_q   <= cfg_data_i;
          CFG_USE_MASK:      use_mask_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule : mono_sprite_blit_clip_mask
`default_nettype wire

// File: tb/tb_mono_sprite_blit_clip_mask.sv
// self-checking testbench for the one-bit sprite blitter: directed table, random sprites, receiver hold-off
`timescale 1ns / 100ps
module tb_mono_sprite_blit_clip_mask;
  import mspb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_CYCLES  = 8;
  localparam int unsigned SPARE_IDX_LO = int'(CFG_USE_MASK) + 1;
  localparam int unsigned SPARE_IDX_HI = 2**CFG_IDX_W - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

  typedef enum bit {STEP_CFG, STEP_BYTE} step_kind_e;

  typedef struct {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [7:0]             sbyte;
    logic [7:0]             mbyte;
    bit                     typed;
    out_item_t              first;   // typed-in first pixel of the byte
  } dir_step_t;

  localparam int DIR_STEPS = 46;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item_i;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item_o;

  // blitter model state
  logic [7:0]         spr_w, spr_h, col_pos, row_pos;
  logic signed [15:0] org_x, org_y;
  logic               mask_on;

  out_item_t expected_pixels [$];
  int        fail_count;
  int        snd_idle_pct, rcv_idle_pct;
  bit        hold_req;

  dir_step_t dir_steps [DIR_STEPS] = '{
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'h00, 1'b1,
      '{1'b1, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h00, 8'hff, 1'b1,
      '{1'b1, 8'd0, 8'd1, 1'b0, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h81, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_USE_MASK, 16'h0001, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'h00, 1'b1, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b0, '0},
    // single pixel sprite in the bottom right corner
    '{STEP_CFG, CFG_SPRITE_WIDTH, 16'hff01, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_HEIGHT, 16'hab01, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_X, 16'd119, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_Y, 16'd59, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h01, 8'h01, 1'b1,
      '{1'b1, 8'd119, 8'd59, 1'b1, 1'b1, 1'b1}},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hfe, 8'h01, 1'b1,
      '{1'b1, 8'd119, 8'd59, 1'b0, 1'b1, 1'b1}},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hfe, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1}},
    '{STEP_CFG, CFG_USE_MASK, 16'hfffe, 8'h00, 8'h00, 1'b0, '0},
    // nine wide sprite straddling the right edge and touching the bottom edge
    '{STEP_CFG, CFG_SPRITE_WIDTH, 16'h0009, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_HEIGHT, 16'h0002, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_X, 16'd112, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_Y, 16'd58, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'ha5, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h01, 8'h00, 1'b0, '0},
    // unlisted register index must not move the position
    '{STEP_CFG, CFG_IDX_SPARE, 16'hffff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h3c, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h01, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_WIDTH, 16'h00ff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_HEIGHT, 16'h00ff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_X, 16'h7fff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_Y, 16'h8000, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b1, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_X, 16'h8000, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_Y, 16'h7fff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b1, '0},
    // empty sprites swallow bytes
    '{STEP_CFG, CFG_SPRITE_WIDTH, 16'h0000, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_WIDTH, 16'h0010, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_SPRITE_HEIGHT, 16'h0000, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hff, 8'hff, 1'b0, '0},
    // clipped on the left and top
    '{STEP_CFG, CFG_SPRITE_HEIGHT, 16'h0003, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_X, 16'hfffc, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_CFG, CFG_DEST_Y, 16'hffff, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h55, 8'haa, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'haa, 8'h55, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h0f, 8'hf0, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'hf0, 8'h0f, 1'b0, '0},
    '{STEP_CFG, CFG_USE_MASK, 16'h0001, 8'h00, 8'h00, 1'b0, '0},
    '{STEP_BYTE, CFG_SPRITE_WIDTH, 16'h0000, 8'h33, 8'hcc, 1'b0, '0}
  };

  mono_sprite_blit_clip_mask u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item_i   (in_item_i),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // pixel writes for one accepted byte, in order, left to right
  task automatic predict_pixels(input logic [7:0] sbyte, input logic [7:0] mbyte,
                                input bit typed, input out_item_t first);
    int        cnt, x, y;
    bit        row_on, last_in_row, last_row;
    out_item_t px;
    if (spr_w == 0 || spr_h == 0) return;
    if (col_pos >= spr_w || row_pos >= spr_h) begin
      col_pos = '0;
      row_pos = '0;
    end
    cnt = int'(spr_w) - int'(col_pos);
    if (cnt > 8) cnt = 8;
    last_in_row = (int'(col_pos) + cnt >= int'(spr_w));
    last_row    = (int'(row_pos) + 1 >= int'(spr_h));
    y = int'(org_y) + int'(row_pos);
    row_on = (y >= 0 && y < int'(SCREEN_HEIGHT));
    for (int i = 0; i < cnt; i++) begin
      x = int'(org_x) + int'(col_pos) + i;
      px.write_pixel  = row_on && x >= 0 && x < int'(SCREEN_WIDTH) && (!mask_on || mbyte[i]);
      px.pixel_x      = px.write_pixel ? x[7:0] : 8'd0;
      px.pixel_y      = px.write_pixel ? y[7:0] : 8'd0;
      px.pixel_value  = px.write_pixel & sbyte[i];
      px.last_of_byte = (i == cnt - 1);
      px.sprite_done  = (i == cnt - 1) && last_in_row && last_row;
      if (typed && i == 0) px = first;
      expected_pixels.push_back(px);
    end
    if (last_in_row) begin
      col_pos = '0;
      row_pos = last_row ? 8'd0 : row_pos + 8'd1;
    end else begin
      col_pos = col_pos + 8'd8;
    end
  endtask

  task automatic send_byte(input logic [7:0] sbyte, input logic [7:0] mbyte,
                           input bit typed, input out_item_t first);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_item_i <= '{sprite_byte: sbyte, mask_byte: mbyte};
    do @(posedge clk_i); while (in_stall);
    predict_pixels(sbyte, mbyte, typed, first);
  endtask

  // caller guarantees the blitter is idle
  task automatic write_blit_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_SPRITE_WIDTH:  spr_w   = data[7:0];
      CFG_SPRITE_HEIGHT: spr_h   = data[7:0];
      CFG_DEST_X:        org_x   = data;
      CFG_DEST_Y:        org_y   = data;
      CFG_USE_MASK:      mask_on = data[0];
      default:           return;
    endcase
    col_pos = '0;
    row_pos = '0;
  endtask

  task automatic wait_blit_idle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_sprites(input int n_items);
    int sent, w, h, total, pick, dx, dy;
    sent = 0;
    while (sent < n_items) begin
      wait_blit_idle();
      pick = $urandom_range(99);
      if (pick < 4)       w = 0;
      else if (pick < 8)  w = 255;
      else if (pick < 16) w = $urandom_range(64, 17);
      else                w = $urandom_range(16, 1);
      pick = $urandom_range(99);
      if (pick < 4)    h = 0;
      else if (w > 64) h = 1;
      else             h = $urandom_range(4, 1);
      case ($urandom_range(9))
        0:       dx = $urandom_range(16'hffff);
        1:       dx = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: dx = int'($urandom_range(150)) - 20;
      endcase
      case ($urandom_range(9))
        0:       dy = $urandom_range(16'hffff);
        1:       dy = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: dy = int'($urandom_range(70)) - 10;
      endcase
      write_blit_reg(CFG_SPRITE_WIDTH, {8'($urandom), 8'(w)});
      write_blit_reg(CFG_SPRITE_HEIGHT, {8'($urandom), 8'(h)});
      write_blit_reg(CFG_DEST_X, 16'(dx));
      write_blit_reg(CFG_DEST_Y, 16'(dy));
      write_blit_reg(CFG_USE_MASK, 16'($urandom));
      if ($urandom_range(4) == 0)
        write_blit_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)), 16'($urandom));
      repeat ($urandom_range(3, 1)) begin
        if (w == 0 || h == 0) total = $urandom_range(2, 1);
        else                  total = ((w + 7) / 8) * h;
        pick = $urandom_range(99);
        // broken sprites cut short, or stray bytes running into the next sprite
        if (pick < 8)       total = $urandom_range(total, 1);
        else if (pick < 16) total = total + $urandom_range(3, 1);
        repeat (total) send_byte(8'($urandom), 8'($urandom), 1'b0, '0);
        if (w != 0 && h != 0) sent += total;
      end
    end
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel result with none expected: got %p", $time, out_item_o);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (want !== out_item_o) begin
          $display("%0t: pixel mismatch: expected wr=%0b x=%0d y=%0d v=%0b last=%0b done=%0b",
                   $time, want.write_pixel, want.pixel_x, want.pixel_y, want.pixel_value,
                   want.last_of_byte, want.sprite_done);
          $display("%0t:                    got wr=%0b x=%0d y=%0d v=%0b last=%0b done=%0b",
                   $time, out_item_o.write_pixel, out_item_o.pixel_x, out_item_o.pixel_y,
                   out_item_o.pixel_value, out_item_o.last_of_byte, out_item_o.sprite_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    hold_req     = 1'b0;
    snd_idle_pct = 19;
    rcv_idle_pct = 60;
    spr_w   = 8'd8;
    spr_h   = 8'd8;
    org_x   = '0;
    org_y   = '0;
    mask_on = 1'b0;
    col_pos = '0;
    row_pos = '0;
    rst_ni      <= 1'b0;
    in_valid    <= 1'b0;
    in_item_i   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_STEPS; k++) begin
      if (dir_steps[k].kind == STEP_CFG) begin
        wait_blit_idle();
        write_blit_reg(dir_steps[k].reg_idx, dir_steps[k].reg_data);
      end else begin
        send_byte(dir_steps[k].sbyte, dir_steps[k].mbyte, dir_steps[k].typed,
                  dir_steps[k].first);
      end
    end

    run_random_sprites(150);

    snd_idle_pct = 60;
    rcv_idle_pct = 19;
    run_random_sprites(150);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // back up the pipeline: the receiver holds off while a full sprite is offered
    wait_blit_idle();
    write_blit_reg(CFG_SPRITE_WIDTH, 16'd64);
    write_blit_reg(CFG_SPRITE_HEIGHT, 16'd4);
    write_blit_reg(CFG_DEST_X, 16'd0);
    write_blit_reg(CFG_DEST_Y, 16'd0);
    write_blit_reg(CFG_USE_MASK, 16'd0);
    hold_req = 1'b1;
    repeat (32) send_byte(8'($urandom), 8'($urandom), 1'b0, '0);
    run_random_sprites(130);

    wait_blit_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mspb_pkg.sv
sv/mspb_lane.sv
sv/mspb_ser.sv
sv/mono_sprite_blit_clip_mask.sv
tb/tb_mono_sprite_blit_clip_mask.sv
